>>> rtl/core/egs_pkg.sv
// Shared types and constants for the elliptical Gaussian sampler.
// Used by every module under rtl/core except egs_checker; no dependencies of its own.
`default_nettype none

package egs_pkg;

  localparam int XY_W     = 18;
  localparam int COEF_W   = 16;
  localparam int PEAK_W   = 32;
  localparam int SAMPLE_W = 32;
  localparam int U_W      = 30;
  localparam int G_W      = 30;
  localparam int A_W      = 31;
  localparam int N_W      = 6;
  localparam int IDX_W    = 3;
  localparam int IN_W     = 40;

  localparam int TAYLOR_TERMS = 8;
  localparam int RECIP_SHIFT  = 34;

  localparam logic [A_W-1:0]  Q30_ONE    = 31'h4000_0000;
  localparam logic [30:0]     LOG2E_Q30  = 31'd1549082005;
  localparam logic [29:0]     LN2_Q30    = 30'd744261118;
  localparam logic [59:0]     FORM_LIMIT = 60'h20_0000_0000;

  localparam logic [COEF_W-1:0] RST_ANGLE_COS  = 16'd16384;
  localparam logic [COEF_W-1:0] RST_ANGLE_SIN  = 16'd0;
  localparam logic [COEF_W-1:0] RST_INV_MAJOR  = 16'd16384;
  localparam logic [COEF_W-1:0] RST_INV_MINOR  = 16'd16384;
  localparam logic [PEAK_W-1:0] RST_PEAK_SCALE = 32'd65536;

  typedef enum logic [IDX_W-1:0] {
    REG_ANGLE_COS  = 3'd0,
    REG_ANGLE_SIN  = 3'd1,
    REG_INV_MAJOR  = 3'd2,
    REG_INV_MINOR  = 3'd3,
    REG_PEAK_SCALE = 3'd4
  } cfg_reg_t;

  // Beat travelling through the exponential section
  typedef struct packed {
    logic           zero;
    logic [N_W-1:0] n;
    logic [G_W-1:0] g;
    logic [A_W-1:0] a;
  } hs_t;

  // ceil(2^34 / k): exact floor division of any 31-bit value by k in 3, 5, 6, 7 (other k return 0)
  function automatic logic [32:0] recip_q34(input int k);
    case (k)
      3:       return 33'd5726623062;
      5:       return 33'd3435973837;
      6:       return 33'd2863311531;
      7:       return 33'd2454267027;
      default: return 33'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/egs_rotate.sv
// Rotation of the pixel offset and scaling by the reciprocal axes, three stages.
// Depends on egs_pkg.
`default_nettype none

module egs_rotate (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         up_valid,
  output logic                              up_ready,
  input  wire logic [egs_pkg::XY_W-1:0]     x_offset,
  input  wire logic [egs_pkg::XY_W-1:0]     y_offset,
  input  wire logic [egs_pkg::COEF_W-1:0]   angle_cos,
  input  wire logic [egs_pkg::COEF_W-1:0]   angle_sin,
  input  wire logic [egs_pkg::COEF_W-1:0]   inv_major,
  input  wire logic [egs_pkg::COEF_W-1:0]   inv_minor,
  output logic                              dn_valid,
  input  wire logic                         dn_ready,
  output logic [egs_pkg::U_W-1:0]           ux,
  output logic [egs_pkg::U_W-1:0]           uy
);
  import egs_pkg::*;

  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;

  logic signed [33:0] xc_r, ys_r, yc_r, xs_r;
  logic signed [33:0] xc_nxt, ys_nxt, yc_nxt, xs_nxt;
  logic signed [34:0] xt, yt;
  logic [33:0] mx_r, my_r, mx_nxt, my_nxt;
  logic [49:0] px, py;
  logic [U_W-1:0] ux_r, uy_r;

  assign en3      = !v3_r || dn_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign up_ready = en1;

  always_comb begin
    xc_nxt = $signed(x_offset) * $signed(angle_cos);
    ys_nxt = $signed(y_offset) * $signed(angle_sin);
    yc_nxt = $signed(y_offset) * $signed(angle_cos);
    xs_nxt = $signed(x_offset) * $signed(angle_sin);
    xt     = 35'(xc_r) + 35'(ys_r);
    yt     = 35'(yc_r) - 35'(xs_r);
    mx_nxt = xt[34] ? 34'(-xt) : xt[33:0];
    my_nxt = yt[34] ? 34'(-yt) : yt[33:0];
    px     = 50'(mx_r) * 50'(inv_major) + 50'(1 << 19);
    py     = 50'(my_r) * 50'(inv_minor) + 50'(1 << 19);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= up_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
    if (en1) begin
      xc_r <= xc_nxt;
      ys_r <= ys_nxt;
      yc_r <= yc_nxt;
      xs_r <= xs_nxt;
    end
    if (en2) begin
      mx_r <= mx_nxt;
      my_r <= my_nxt;
    end
    if (en3) begin
      ux_r <= px[49:20];
      uy_r <= py[49:20];
    end
  end

  assign dn_valid = v3_r;
  assign ux       = ux_r;
  assign uy       = uy_r;

endmodule

`default_nettype wire

>>> rtl/core/egs_form.sv
// Quadratic form, cutoff test and base-2 split of the exponent, four stages.
// Depends on egs_pkg.
`default_nettype none

module egs_form (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 up_valid,
  output logic                      up_ready,
  input  wire logic [egs_pkg::U_W-1:0] ux,
  input  wire logic [egs_pkg::U_W-1:0] uy,
  output logic                      dn_valid,
  input  wire logic                 dn_ready,
  output egs_pkg::hs_t              dn_data
);
  import egs_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  logic [59:0] sqx_r, sqy_r;
  logic [60:0] sum;
  logic [59:0] q, qr;
  logic [21:0] q16_r;
  logic        zero2_r, zero3_r, zero4_r;
  logic [52:0] tp;
  logic [N_W-1:0] n3_r, n4_r;
  logic [29:0] f_r;
  logic [59:0] gp;
  logic [G_W-1:0] g_r;

  assign en4      = !v4_r || dn_ready;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign up_ready = en1;

  always_comb begin
    sum = 61'(sqx_r) + 61'(sqy_r);
    q   = sum[60:1];
    qr  = q + 60'(1 << 15);
    tp  = 53'(q16_r) * 53'(LOG2E_Q30) + 53'(1 << 15);
    gp  = 60'(f_r) * 60'(LN2_Q30) + 60'(1 << 29);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= up_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
    if (en1) begin
      sqx_r <= 60'(ux) * 60'(ux);
      sqy_r <= 60'(uy) * 60'(uy);
    end
    if (en2) begin
      zero2_r <= q > FORM_LIMIT;
      q16_r   <= qr[37:16];
    end
    if (en3) begin
      zero3_r <= zero2_r;
      n3_r    <= tp[51:46];
      f_r     <= tp[45:16];
    end
    if (en4) begin
      zero4_r <= zero3_r;
      n4_r    <= n3_r;
      g_r     <= gp[59:30];
    end
  end

  assign dn_valid = v4_r;
  assign dn_data  = '{zero: zero4_r, n: n4_r, g: g_r, a: Q30_ONE};

endmodule

`default_nettype wire

>>> rtl/core/egs_horner_step.sv
// One Horner step of the exp(-g) series: a = 1 - round(g*a)/K, two stages.
// Depends on egs_pkg.
`default_nettype none

module egs_horner_step #(
  parameter int K = 8
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    up_valid,
  output logic         up_ready,
  input  wire egs_pkg::hs_t up_data,
  output logic         dn_valid,
  input  wire logic    dn_ready,
  output egs_pkg::hs_t dn_data
);
  import egs_pkg::*;

  logic v1_r, v2_r;
  logic en1, en2;
  hs_t  s1_r, s2_r;
  logic [60:0] pp;
  logic [A_W-1:0] p_r;
  logic [A_W-1:0] quot;

  assign en2      = !v2_r || dn_ready;
  assign en1      = !v1_r || en2;
  assign up_ready = en1;

  assign pp = 61'(up_data.g) * 61'(up_data.a) + 61'(1 << 29);

  generate
    if ((K & (K - 1)) == 0) begin : g_pow2
      assign quot = p_r >> $clog2(K);
    end else begin : g_recip
      logic [63:0] qp;
      assign qp   = 64'(p_r) * 64'(recip_q34(K));
      assign quot = A_W'(qp[63:RECIP_SHIFT]);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= up_valid;
      if (en2) v2_r <= v1_r;
    end
    if (en1) begin
      s1_r <= up_data;
      p_r  <= pp[60:30];
    end
    if (en2) begin
      s2_r <= '{zero: s1_r.zero, n: s1_r.n, g: s1_r.g, a: Q30_ONE - quot};
    end
  end

  assign dn_valid = v2_r;
  assign dn_data  = s2_r;

endmodule

`default_nettype wire

>>> rtl/core/egs_scale.sv
// Power-of-two scaling of the series result, peak multiply, rounding and
// saturation into the output register; three stages. Depends on egs_pkg.
`default_nettype none

module egs_scale (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           up_valid,
  output logic                                up_ready,
  input  wire egs_pkg::hs_t                   up_data,
  input  wire logic [egs_pkg::PEAK_W-1:0]     peak_scale,
  output logic                                dn_valid,
  input  wire logic                           dn_ready,
  output logic [egs_pkg::SAMPLE_W-1:0]        sample_value
);
  import egs_pkg::*;

  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;
  logic [39:0] sh;
  logic [A_W-1:0] e_nxt, e_r;
  logic [62:0] prod_r;
  logic [63:0] rr;
  logic [SAMPLE_W-1:0] out_r;

  assign en3      = !v3_r || dn_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign up_ready = en1;

  always_comb begin
    sh = (40'(up_data.a) + (40'd1 << (up_data.n - N_W'(1)))) >> up_data.n;
    if (up_data.zero || up_data.n >= N_W'(40)) begin
      e_nxt = '0;
    end else if (up_data.n == '0) begin
      e_nxt = up_data.a;
    end else begin
      e_nxt = sh[A_W-1:0];
    end
    rr = 64'(prod_r) + 64'(1 << 29);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= up_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
    if (en1) e_r    <= e_nxt;
    if (en2) prod_r <= 63'(e_r) * 63'(peak_scale);
    // saturate anything at or above 2^32
    if (en3) out_r  <= (rr[63:62] != 2'b00) ? '1 : rr[61:30];
  end

  assign dn_valid     = v3_r;
  assign sample_value = out_r;

endmodule

`default_nettype wire

>>> rtl/core/elliptical_gaussian_sampler.sv
// Rotated elliptical 2-D Gaussian sampler: one pixel offset in, one Q16.16
// sample out. Depends on egs_pkg, egs_rotate, egs_form, egs_horner_step, egs_scale.
//
// Takes one offset beat per cycle and gives one sample beat per cycle while
// out_tready is high. The pipeline runs through the rotate/scale stages, the
// quadratic form and exponent split stages, one Horner step for each of the 8
// series terms and the final scaling stages. Every stage holds its beat while
// the next one is full, so bubbles close up and in_tready stays high whenever
// out_tready is high. Load the five spot registers through the cfg port while
// no beat is in flight; a write is taken every cycle and indexes beyond the list are dropped.
`default_nettype none

module elliptical_gaussian_sampler (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [egs_pkg::IN_W-1:0]        in_tdata,   // x_offset[17:0], y_offset[35:18], zero pad
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [egs_pkg::SAMPLE_W-1:0]         out_tdata,  // sample_value[31:0]
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [egs_pkg::IDX_W-1:0]       cfg_index,
  input  wire logic [31:0]                     cfg_data
);
  import egs_pkg::*;

  logic [COEF_W-1:0] angle_cos_r, angle_sin_r, inv_major_r, inv_minor_r;
  logic [PEAK_W-1:0] peak_scale_r;

  logic           rot_valid, rot_ready;
  logic [U_W-1:0] ux, uy;
  logic           hv [0:TAYLOR_TERMS];
  logic           hr [0:TAYLOR_TERMS];
  hs_t            hd [0:TAYLOR_TERMS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_cos_r  <= RST_ANGLE_COS;
      angle_sin_r  <= RST_ANGLE_SIN;
      inv_major_r  <= RST_INV_MAJOR;
      inv_minor_r  <= RST_INV_MINOR;
      peak_scale_r <= RST_PEAK_SCALE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ANGLE_COS:  angle_cos_r  <= cfg_data[COEF_W-1:0];
        REG_ANGLE_SIN:  angle_sin_r  <= cfg_data[COEF_W-1:0];
        REG_INV_MAJOR:  inv_major_r  <= cfg_data[COEF_W-1:0];
        REG_INV_MINOR:  inv_minor_r  <= cfg_data[COEF_W-1:0];
        REG_PEAK_SCALE: peak_scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  egs_rotate u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (in_tvalid),
    .up_ready  (in_tready),
    .x_offset  (in_tdata[XY_W-1:0]),
    .y_offset  (in_tdata[2*XY_W-1:XY_W]),
    .angle_cos (angle_cos_r),
    .angle_sin (angle_sin_r),
    .inv_major (inv_major_r),
    .inv_minor (inv_minor_r),
    .dn_valid  (rot_valid),
    .dn_ready  (rot_ready),
    .ux        (ux),
    .uy        (uy)
  );

  egs_form u_form (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (rot_valid),
    .up_ready (rot_ready),
    .ux       (ux),
    .uy       (uy),
    .dn_valid (hv[0]),
    .dn_ready (hr[0]),
    .dn_data  (hd[0])
  );

  for (genvar i = 0; i < TAYLOR_TERMS; i++) begin : g_term
    egs_horner_step #(.K(TAYLOR_TERMS - i)) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (hv[i]),
      .up_ready (hr[i]),
      .up_data  (hd[i]),
      .dn_valid (hv[i+1]),
      .dn_ready (hr[i+1]),
      .dn_data  (hd[i+1])
    );
  end

  egs_scale u_scale (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (hv[TAYLOR_TERMS]),
    .up_ready     (hr[TAYLOR_TERMS]),
    .up_data      (hd[TAYLOR_TERMS]),
    .peak_scale   (peak_scale_r),
    .dn_valid     (out_tvalid),
    .dn_ready     (out_tready),
    .sample_value (out_tdata)
  );

endmodule

`default_nettype wire

>>> rtl/core/egs_checker.sv
// Port-level checks for the elliptical Gaussian sampler, bound to the top level.
// Depends on elliptical_gaussian_sampler.
`default_nettype none

module egs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // an empty or draining output never back-pressures the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input stalled while output can move");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("output beat dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata))
    else $error("stalled output beat changed");

endmodule

bind elliptical_gaussian_sampler egs_checker u_egs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
